/* hdl/rps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the retrying packet sender.
// No dependencies; imported by the top level and used for the item structs.
package rps_pkg;

    localparam int STORE_DEPTH  = 31;
    localparam int PACKET_BYTES = 32;
    localparam int ECHO_OFFSET  = 4;
    localparam int POS_W        = 5;
    localparam int RXPOS_W      = 6;

    // action codes
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_TRIGGER = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;
    localparam logic [1:0] ACT_RX      = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_TX      = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // sender modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_SEND  = 2'd1;
    localparam logic [1:0] MODE_ACKED = 2'd2;

    // outcomes
    localparam logic [1:0] OUT_PENDING = 2'd0;
    localparam logic [1:0] OUT_OK      = 2'd1;
    localparam logic [1:0] OUT_FAIL    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SEND_ONCE   = 2'd0;
    localparam logic [1:0] CFG_MAX_TRIES   = 2'd1;
    localparam logic [1:0] CFG_KEYWORD_LEN = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       byte_value;
        logic [POS_W-1:0] byte_pos;
        logic [POS_W-1:0] message_len;
        logic             rx_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       run_last;
        logic [1:0] mode;
        logic [1:0] outcome;
        logic       accepted;
        logic [7:0] sequence_res;
        logic [7:0] tries_done;
    } t_out_item;

endpackage

/* hdl/rps_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while no read is enabled. No dependencies.
module rps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/retrying_packet_sender.sv */
`timescale 1ns / 1ps
// Retrying packet sender: stop-and-wait transmit with a retry limit.
// Uses rps_pkg for item structs and codes, and rps_ram for the message store.
//
// Usage:
//   Input items (i_in, valid/ready) load message bytes, trigger a send, tick
//   the retry timer or deliver received packet bytes. Result items leave on
//   o_out (valid/ready); a trigger in idle mode or a tick while sending yields
//   one transmit item per packet byte (sequence byte, then message), else one.
//   The config channel writes send_once, max_tries and keyword_len; write it
//   only while no item is in flight.
// Timing:
//   One item is worked on at a time. Load, trigger-when-busy and tick without
//   a resend pass through S_ONE, a received byte through S_RX (one message
//   store read) then S_ONE; a packet streams through S_TX one byte per cycle
//   from the store's registered read port while the receiver keeps up. The
//   result register lets the next item be accepted while the last result
//   still waits; if the receiver stalls, the stream holds in place.
// Reset:
//   Synchronous, active low: idle, outcome pending, counters cleared,
//   config registers at their defaults. The message store is not cleared.
module retrying_packet_sender
    import rps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RX,
        S_ONE,
        S_TX
    } t_state;

    localparam logic [POS_W-1:0]   STORE_TOP = POS_W'(STORE_DEPTH);
    localparam logic [RXPOS_W-1:0] ECHO_OFF  = RXPOS_W'(ECHO_OFFSET);
    localparam logic [RXPOS_W:0]   PKT_LIM   = (RXPOS_W + 1)'(PACKET_BYTES);
    localparam logic [RXPOS_W-1:0] RXPOS_MAX = '1;

    t_state             r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic [1:0]         r_outcome, n_outcome;
    logic [7:0]         r_tries, n_tries;
    logic [7:0]         r_seq, n_seq;
    logic [POS_W-1:0]   r_len, n_len;
    logic [RXPOS_W-1:0] r_rx_pos, n_rx_pos;
    logic               r_match, n_match;
    logic               r_send_once, n_send_once;
    logic [7:0]         r_max_tries, n_max_tries;
    logic [POS_W-1:0]   r_kw_len, n_kw_len;
    t_in_item           r_in, n_in;
    logic [POS_W-1:0]   r_idx, n_idx;
    logic               r_acc, n_acc;
    logic [1:0]         r_one_kind, n_one_kind;
    logic [7:0]         r_one_data, n_one_data;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               ram_we;
    logic [POS_W-1:0]   ram_wr_addr;
    logic [7:0]         ram_wr_data;
    logic               ram_re;
    logic [POS_W-1:0]   ram_rd_addr;
    logic [7:0]         ram_rd_data;

    logic               in_fire;
    logic               slot_free;
    logic [7:0]         tries_inc;
    logic [RXPOS_W-1:0] rx_off;
    logic [RXPOS_W-1:0] kw_end;
    logic               in_pkt;
    logic               do_cmp;
    logic [7:0]         echo_byte;
    logic               match_now;
    logic               fwd;
    logic               complete;

    rps_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_re      (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_fire   = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign tries_inc = r_tries + 8'd1;

    // echo check and payload window for a received byte
    assign rx_off    = r_rx_pos - ECHO_OFF;
    assign kw_end    = ECHO_OFF + {1'b0, r_kw_len};
    assign in_pkt    = {1'b0, r_rx_pos} < PKT_LIM;
    assign do_cmp    = in_pkt && (r_rx_pos >= ECHO_OFF) && (r_rx_pos < kw_end);
    assign echo_byte = (rx_off < {1'b0, r_len}) ? ram_rd_data : 8'd0;
    assign match_now = r_match && !(do_cmp && (r_in.byte_value != echo_byte));
    assign fwd       = in_pkt && match_now && (r_mode == MODE_SEND)
                       && (r_rx_pos >= (ECHO_OFF + RXPOS_W'(1) + {1'b0, r_len}));
    assign complete  = (({1'b0, r_rx_pos} + 7'd1) >= {1'b0, kw_end})
                       && ({1'b0, kw_end} <= PKT_LIM);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_outcome   = r_outcome;
        n_tries     = r_tries;
        n_seq       = r_seq;
        n_len       = r_len;
        n_rx_pos    = r_rx_pos;
        n_match     = r_match;
        n_send_once = r_send_once;
        n_max_tries = r_max_tries;
        n_kw_len    = r_kw_len;
        n_in        = r_in;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_one_kind  = r_one_kind;
        n_one_data  = r_one_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_wr_addr = i_in.byte_pos;
        ram_wr_data = i_in.byte_value;
        ram_re      = 1'b0;
        ram_rd_addr = r_idx;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEND_ONCE:   n_send_once = i_cfg_data[0];
                CFG_MAX_TRIES:   n_max_tries = i_cfg_data;
                CFG_KEYWORD_LEN: n_kw_len    = i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_in       = i_in;
                    n_acc      = 1'b0;
                    n_idx      = '0;
                    n_one_kind = KIND_STATUS;
                    n_one_data = 8'd0;
                    n_state    = S_ONE;
                    unique case (i_in.action)
                        ACT_LOAD: begin
                            ram_we = (i_in.byte_pos < STORE_TOP);
                        end
                        ACT_TRIGGER: begin
                            if (r_mode == MODE_IDLE) begin
                                n_len     = i_in.message_len;
                                n_seq     = r_seq + 8'd1;
                                n_acc     = 1'b1;
                                n_mode    = r_send_once ? MODE_IDLE : MODE_SEND;
                                n_outcome = r_send_once ? OUT_OK : OUT_PENDING;
                                n_state   = S_TX;
                            end
                        end
                        ACT_TICK: begin
                            if (r_mode == MODE_SEND) begin
                                n_state = S_TX;
                                if (tries_inc >= r_max_tries) begin
                                    n_tries   = 8'd0;
                                    n_mode    = MODE_IDLE;
                                    n_outcome = OUT_FAIL;
                                end else begin
                                    n_tries = tries_inc;
                                end
                            end else if (r_mode == MODE_ACKED) begin
                                n_mode    = MODE_IDLE;
                                n_tries   = 8'd0;
                                n_outcome = OUT_OK;
                            end
                        end
                        ACT_RX: begin
                            // fetch the keyword byte this position would echo
                            ram_rd_addr = rx_off[POS_W-1:0];
                            ram_re      = (rx_off < {1'b0, STORE_TOP});
                            n_state     = S_RX;
                        end
                        default: ;
                    endcase
                end
            end
            S_RX: begin
                n_match = match_now;
                if (fwd) begin
                    n_one_kind = KIND_PAYLOAD;
                    n_one_data = r_in.byte_value;
                end
                if (r_in.rx_last) begin
                    if (match_now && complete && (r_mode == MODE_SEND)) begin
                        n_mode = MODE_ACKED;
                    end
                    n_rx_pos = '0;
                    n_match  = 1'b1;
                end else if (r_rx_pos != RXPOS_MAX) begin
                    n_rx_pos = r_rx_pos + RXPOS_W'(1);
                end
                n_state = S_ONE;
            end
            S_ONE: begin
                if (slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out.kind         = r_one_kind;
                    n_out.data         = r_one_data;
                    n_out.run_last     = 1'b1;
                    n_out.mode         = r_mode;
                    n_out.outcome      = r_outcome;
                    n_out.accepted     = 1'b0;
                    n_out.sequence_res = r_seq;
                    n_out.tries_done   = r_tries;
                    n_state            = S_IDLE;
                end
            end
            S_TX: begin
                if (slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out.kind         = KIND_TX;
                    n_out.data         = (r_idx == '0) ? r_seq : ram_rd_data;
                    n_out.run_last     = (r_idx == r_len);
                    n_out.mode         = r_mode;
                    n_out.outcome      = r_outcome;
                    n_out.accepted     = r_acc;
                    n_out.sequence_res = r_seq;
                    n_out.tries_done   = r_tries;
                    // prefetch the store byte for the next packet byte
                    ram_rd_addr        = r_idx;
                    ram_re             = (r_idx < r_len);
                    if (r_idx == r_len) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + POS_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_outcome   <= OUT_PENDING;
            r_tries     <= 8'd0;
            r_seq       <= 8'd0;
            r_len       <= '0;
            r_rx_pos    <= '0;
            r_match     <= 1'b1;
            r_send_once <= 1'b0;
            r_max_tries <= 8'd5;
            r_kw_len    <= POS_W'(4);
            r_idx       <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_outcome   <= n_outcome;
            r_tries     <= n_tries;
            r_seq       <= n_seq;
            r_len       <= n_len;
            r_rx_pos    <= n_rx_pos;
            r_match     <= n_match;
            r_send_once <= n_send_once;
            r_max_tries <= n_max_tries;
            r_kw_len    <= n_kw_len;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
        r_in       <= n_in;
        r_one_kind <= n_one_kind;
        r_one_data <= n_one_data;
        r_out      <= n_out;
    end

endmodule
